// File: src/lprw_pkg.sv
`timescale 1ns / 1ps

package lprw_pkg;

  localparam int MAX_CAPACITY_DEF = 65536;
  localparam int FIFO_DEPTH       = 2;
  localparam int NUM_DIGITS       = 20;
  localparam int CONV_STEPS       = 64;

  localparam logic [2:0] KIND_BEGIN   = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_DECIMAL = 3'd3;
  localparam logic [2:0] KIND_FINISH  = 3'd4;

  localparam logic [31:0] ABSENT_MARK = 32'hFFFF_FFFF;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [16:0] CAP_RESET   = 17'h10000;

  typedef struct packed {
    logic [2:0]                  kind;
    logic [31:0]                 len;
    logic [7:0]                  data;
    logic [NUM_DIGITS-1:0][3:0]  bcd;
    logic [4:0]                  nd;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_offset;
    logic        is_last;
    logic        is_total;
    logic [16:0] total_length;
    logic        overflowed;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    EM_BYTES,
    EM_VALUE,
    EM_TOTAL
  } emit_mode_e;

endpackage

// File: src/lprw_front.sv
`timescale 1ns / 1ps

module lprw_front
  import lprw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   kind_i,
  input  logic [31:0]  record_length_i,
  input  logic [7:0]   data_byte_i,
  input  logic [63:0]  decimal_value_i,
  output logic         push_o,
  output cmd_t         push_cmd_o,
  input  logic         full_i
);

  front_state_e st_q, st_d;
  cmd_t         cmd_q, cmd_d;
  logic [63:0]  val_q, val_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         accept;
  logic [NUM_DIGITS-1:0][3:0] adj;
  logic [4:0]   nd;

  assign in_ready_o = (st_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (st_q == F_PUSH) && !full_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      F_IDLE: begin
        if (accept) begin
          st_d = (kind_i == KIND_DECIMAL) ? F_CONV : F_PUSH;
        end
      end
      F_CONV: begin
        if (cnt_q == 6'(CONV_STEPS - 1)) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Shift-add-3 conversion, one binary bit per cycle, most significant first.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (cmd_q.bcd[i] >= 4'd5) ? cmd_q.bcd[i] + 4'd3 : cmd_q.bcd[i];
    end
  end

  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (cmd_q.bcd[i] != 4'd0) begin
        nd = 5'(i + 1);
      end
    end
  end

  always_comb begin
    cmd_d = cmd_q;
    val_d = val_q;
    cnt_d = cnt_q;
    if (accept) begin
      cmd_d.kind = kind_i;
      cmd_d.len  = record_length_i;
      cmd_d.data = data_byte_i;
      cmd_d.bcd  = '0;
      cmd_d.nd   = 5'd0;
      val_d      = decimal_value_i;
      cnt_d      = 6'd0;
    end else if (st_q == F_CONV) begin
      cmd_d.bcd = {adj[NUM_DIGITS-1:0]} << 1 | {{(4*NUM_DIGITS-1){1'b0}}, val_q[63]};
      val_d     = {val_q[62:0], 1'b0};
      cnt_d     = cnt_q + 6'd1;
    end
  end

  always_comb begin
    push_cmd_o    = cmd_q;
    push_cmd_o.nd = nd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      cnt_q <= 6'd0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
  end

endmodule

// File: src/lprw_fifo.sv
`timescale 1ns / 1ps

module lprw_fifo
  import lprw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  cmd_t            mem [FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_cmd_i;
    end
  end

endmodule

// File: src/lprw_back.sv
`timescale 1ns / 1ps

module lprw_back
  import lprw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [16:0] cap_i,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_o
);

  back_state_e st_q, st_d;
  logic [16:0] wp_q, wp_d;
  logic        ovf_q, ovf_d;
  logic [31:0] bl_q, bl_d;
  logic        vf_q, vf_d;
  logic [4:0]  idx_q, idx_d;
  logic [4:0]  cnt_q, cnt_d;
  emit_mode_e  mode_q, mode_d;
  logic [3:0][7:0] pfx_q, pfx_d;
  logic [NUM_DIGITS-1:0][3:0] bcd_q, bcd_d;
  logic [4:0]  nd_q, nd_d;
  logic [7:0]  dbyte_q, dbyte_d;
  logic        o_v_q, o_v_d;
  res_t        o_q, o_d;

  logic        adv, last;
  logic [33:0] sum4, sum_n;
  logic [31:0] n_sel;
  logic        pre_ok, fits;
  logic [4:0]  pos;
  logic [7:0]  cur_byte;

  assign pop_o       = (st_q == B_IDLE) && !empty_i;
  assign adv         = (st_q == B_EMIT) && (!o_v_q || out_ready_i);
  assign last        = (idx_q == cnt_q - 5'd1);
  assign out_valid_o = o_v_q;
  assign out_o       = o_q;

  assign n_sel  = (head_i.kind == KIND_DECIMAL) ? 32'(head_i.nd) : head_i.len;
  assign sum4   = 34'(wp_q) + 34'd4;
  assign sum_n  = sum4 + 34'(n_sel);
  assign pre_ok = !ovf_q && (sum4 <= 34'(cap_i));
  assign fits   = sum_n <= 34'(cap_i);

  assign pos = nd_q + 5'd3 - idx_q;

  always_comb begin
    cur_byte = 8'd0;
    unique case (mode_q)
      EM_VALUE: cur_byte = dbyte_q;
      EM_BYTES: begin
        if (idx_q < 5'd4) begin
          cur_byte = pfx_q[~idx_q[1:0]];
        end else begin
          cur_byte = ASCII_ZERO + {4'd0, bcd_q[pos]};
        end
      end
      default: cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      B_IDLE: begin
        if (pop_o && (cnt_d != 5'd0)) begin
          st_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (adv && last) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    wp_d    = wp_q;
    ovf_d   = ovf_q;
    bl_d    = bl_q;
    vf_d    = vf_q;
    idx_d   = idx_q;
    cnt_d   = 5'd0;
    mode_d  = mode_q;
    pfx_d   = pfx_q;
    bcd_d   = bcd_q;
    nd_d    = nd_q;
    dbyte_d = dbyte_q;
    o_v_d   = o_v_q;
    o_d     = o_q;
    if (st_q == B_EMIT) begin
      cnt_d = cnt_q;
    end
    if (pop_o) begin
      idx_d = 5'd0;
      unique case (head_i.kind)
        KIND_BEGIN: begin
          wp_d  = 17'd0;
          ovf_d = 1'b0;
          bl_d  = 32'd0;
          vf_d  = 1'b0;
        end
        KIND_HEADER: begin
          bl_d   = 32'd0;
          vf_d   = 1'b0;
          mode_d = EM_BYTES;
          pfx_d  = (head_i.len == 32'd0) ? ABSENT_MARK : head_i.len;
          if (head_i.len == ABSENT_MARK) begin
            ovf_d = 1'b1;
          end else begin
            if (head_i.len != 32'd0) begin
              bl_d = head_i.len;
            end
            if (!pre_ok) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d = 5'd4;
              if (head_i.len != 32'd0) begin
                vf_d = fits;
                if (!fits) begin
                  ovf_d = 1'b1;
                end
              end
            end
          end
        end
        KIND_VALUE: begin
          mode_d  = EM_VALUE;
          dbyte_d = head_i.data;
          if (bl_q != 32'd0) begin
            bl_d = bl_q - 32'd1;
            if (vf_q && !ovf_q) begin
              cnt_d = 5'd1;
            end
            if (bl_q == 32'd1) begin
              vf_d = 1'b0;
            end
          end
        end
        KIND_DECIMAL: begin
          bl_d   = 32'd0;
          vf_d   = 1'b0;
          mode_d = EM_BYTES;
          pfx_d  = 32'(head_i.nd);
          bcd_d  = head_i.bcd;
          nd_d   = head_i.nd;
          if (!pre_ok) begin
            ovf_d = 1'b1;
          end else if (fits) begin
            cnt_d = 5'd4 + head_i.nd;
          end else begin
            cnt_d = 5'd4;
            ovf_d = 1'b1;
          end
        end
        KIND_FINISH: begin
          mode_d = EM_TOTAL;
          cnt_d  = 5'd1;
        end
        default: begin
          cnt_d = 5'd0;
        end
      endcase
    end
    if (adv) begin
      o_v_d   = 1'b1;
      o_d.is_last = last;
      idx_d   = idx_q + 5'd1;
      if (mode_q == EM_TOTAL) begin
        o_d.out_byte     = 8'd0;
        o_d.byte_offset  = 16'd0;
        o_d.is_total     = 1'b1;
        o_d.total_length = ovf_q ? 17'd0 : wp_q;
        o_d.overflowed   = ovf_q;
      end else begin
        o_d.out_byte     = cur_byte;
        o_d.byte_offset  = wp_q[15:0];
        o_d.is_total     = 1'b0;
        o_d.total_length = 17'd0;
        o_d.overflowed   = 1'b0;
        wp_d             = wp_q + 17'd1;
      end
    end else if (out_ready_i) begin
      o_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      wp_q  <= 17'd0;
      ovf_q <= 1'b0;
      bl_q  <= 32'd0;
      vf_q  <= 1'b0;
      idx_q <= 5'd0;
      cnt_q <= 5'd0;
      o_v_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      wp_q  <= wp_d;
      ovf_q <= ovf_d;
      bl_q  <= bl_d;
      vf_q  <= vf_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      o_v_q <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    pfx_q   <= pfx_d;
    bcd_q   <= bcd_d;
    nd_q    <= nd_d;
    dbyte_q <= dbyte_d;
    o_q     <= o_d;
  end

  // A record whose value is being written can never coexist with overflow.
  a_fits_no_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vf_q |-> !ovf_q)
    else $error("value_fits set while overflow is set");

  a_fits_needs_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bl_q == 32'd0) |-> !vf_q)
    else $error("value_fits set with no value bytes pending");

  a_emit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_EMIT) |-> (idx_q < cnt_q))
    else $error("emit index beyond planned count");

  a_no_pop_while_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_EMIT) |-> !pop_o)
    else $error("command taken while results are pending");

endmodule

// File: src/length_prefixed_record_writer.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata / tuser contents
// s_axis    in         tdata: record_length, data_byte, decimal_value; tuser: kind
// m_axis    out        tdata: out_byte, byte_offset, total_length, overflowed;
//                      tuser: is_total; tlast: is_last
// apb       in/out     register 0 at byte address 0: capacity
//
// The front takes one item at a time and accepts the next only once the last is
// queued; a decimal item first goes through shift-add-3 conversion, then is queued.
// The back pops a command while idle and then emits its result bytes in order,
// so a header yields at most four bytes and a decimal record at most 24.
// Reset clears all record state and sets capacity to 65536; no clearing pass.
// A result that is not taken stalls the back in the output register; the queue
// then fills and the front stops accepting items.

module length_prefixed_record_writer
  import lprw_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // record_length, data_byte, decimal_value
  input  logic [2:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // out_byte, byte_offset, total_length, overflowed
  output logic         m_axis_tuser,  // is_total
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [16:0] cap_q, cap_d;
  logic [16:0] cap_eff;
  logic        push, full, pop, empty;
  cmd_t        push_cmd, head;
  res_t        res;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == 1'b0) ? {15'd0, cap_q} : 32'd0;
  assign cap_eff = (34'(cap_q) > 34'(MAX_CAPACITY)) ? 17'(MAX_CAPACITY) : cap_q;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      cap_d = pwdata[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  lprw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .kind_i          (s_axis_tuser),
    .record_length_i (s_axis_tdata[31:0]),
    .data_byte_i     (s_axis_tdata[39:32]),
    .decimal_value_i (s_axis_tdata[103:40]),
    .push_o          (push),
    .push_cmd_o      (push_cmd),
    .full_i          (full)
  );

  lprw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  lprw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_eff),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.overflowed, res.total_length, res.byte_offset,
                         res.out_byte};
  assign m_axis_tuser = res.is_total;
  assign m_axis_tlast = res.is_last;

endmodule
